// ===== sv/strongly_connected_components_macros.svh =====
// Assertion macros shared by the strongly connected components RTL.
// Depends on nothing; included by modules that check their own logic.
`ifndef STRONGLY_CONNECTED_COMPONENTS_MACROS_SVH
`define STRONGLY_CONNECTED_COMPONENTS_MACROS_SVH
`define SCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== sv/scc_pkg.sv =====
// Package for the strongly connected components block: sizes, codes, payload types.
// Depends on nothing.
`default_nettype none
package scc_pkg;
    localparam int MaxNodes = 1024;
    localparam int MaxEdges = 4096;
    localparam int NodeW = $clog2(MaxNodes);
    localparam int EdgeW = $clog2(MaxEdges);

    localparam logic [1:0] KindAdd   = 2'd0;
    localparam logic [1:0] KindRun   = 2'd1;
    localparam logic [1:0] KindQuery = 2'd2;
    localparam logic [1:0] KindClear = 2'd3;

    localparam logic [1:0] StatOk      = 2'd0;
    localparam logic [1:0] StatNotRun  = 2'd1;
    localparam logic [1:0] StatRange   = 2'd2;
    localparam logic [1:0] StatFull    = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [10:0] first_node;
        logic [10:0] second_node;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic        same_component;
        logic [10:0] component_total;
    } t_out;
endpackage
`default_nettype wire

// ===== sv/strongly_connected_components.sv =====
// Strongly connected components (Kosaraju) over a stored directed edge list.
// Depends on scc_pkg and strongly_connected_components_macros.svh.
//
// Usage: items arrive on i_in_valid/o_in_ready with payload i_in (scc_pkg::t_in)
// and each gives one result on o_out_valid/i_out_ready with payload o_out.
// The node_count register is written with i_cfg_we/i_cfg_data; the user must
// write it only while idle, as the block does not enforce this. One item is
// worked at a time. Add and clear results are offered from the output register
// after state S_QRD, query results after S_QRD and S_QCMP. The next item is
// taken the cycle after the output transfer. A run first clears the mark and
// label memories over all 1024 entries. Its run time is then set by the single
// read port of the edge memories, since in both passes every node that is
// walked scans the whole edge list.
// Reset (synchronous, active low) empties the graph, drops the computed
// labels and sets node_count to 1024; the memories need no clearing at reset.
// While the receiver stalls the result waits in the output register and no
// new item is taken until it has been transferred.
`default_nettype none
`include "strongly_connected_components_macros.svh"
module strongly_connected_components (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [10:0]   i_cfg_data,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire scc_pkg::t_in  i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output scc_pkg::t_out      o_out
);
    localparam int NW = scc_pkg::NodeW;
    localparam int EW = scc_pkg::EdgeW;

    typedef enum logic [4:0] {
        S_IDLE, S_QRD, S_QCMP, S_CLR, S_F_SEL, S_F_RD, S_F_TOP, S_F_ERD, S_F_EWAIT,
        S_F_ECHK, S_F_VWAIT, S_F_VCHK, S_B_POP, S_B_LWAIT, S_B_LCHK, S_B_TOP,
        S_B_ERD, S_B_EWAIT, S_B_ECHK, S_B_LWAIT2, S_B_LCHK2, S_OUT
    } t_state;

    t_state r_state;
    logic [10:0] r_node_count;
    logic [EW:0] r_edge_total;
    logic r_ready_lbl;
    scc_pkg::t_in r_item;
    scc_pkg::t_out r_out;
    logic [10:0] r_n;
    logic [NW:0] r_cnt;
    logic [NW:0] r_sp;
    logic [NW:0] r_fin;
    logic [10:0] r_count;
    logic [10:0] r_u;
    logic [EW:0] r_p;
    logic [10:0] r_a;
    logic [10:0] r_b;

    logic [10:0] m_efrom [scc_pkg::MaxEdges];
    logic [10:0] m_eto   [scc_pkg::MaxEdges];
    logic        m_vis   [scc_pkg::MaxNodes];
    logic [10:0] m_lbl   [scc_pkg::MaxNodes];
    logic [10:0] m_fin   [scc_pkg::MaxNodes];
    logic [10:0] m_snode [scc_pkg::MaxNodes];
    logic [EW:0] m_spos  [scc_pkg::MaxNodes];

    logic [10:0] r_efrom_q, r_eto_q, r_lbl_q, r_fin_q, r_snode_q;
    logic        r_vis_q;
    logic [EW:0] r_spos_q;

    logic [10:0] w_n_eff;
    assign w_n_eff = (r_node_count > 11'(scc_pkg::MaxNodes)) ? 11'(scc_pkg::MaxNodes)
                                                            : r_node_count;

    function automatic logic node_ok(input logic [10:0] v, input logic [10:0] n);
        return (v != 11'd0) && (v <= n);
    endfunction

    function automatic logic [NW-1:0] nidx(input logic [10:0] v);
        return NW'(v - 11'd1);
    endfunction

    logic w_add_ok;
    assign w_add_ok = node_ok(r_item.first_node, w_n_eff)
                   && node_ok(r_item.second_node, w_n_eff);

    // Memory port controls.
    logic          e_we;
    logic [EW-1:0] e_wa, e_ra;
    logic          v_we, v_wd;
    logic [NW-1:0] v_wa, v_ra;
    logic          l_we;
    logic [10:0]   l_wd;
    logic [NW-1:0] l_wa, l_ra;
    logic          f_we;
    logic [NW-1:0] f_wa, f_ra;
    logic [10:0]   f_wd;
    logic          s_we;
    logic [NW-1:0] s_wa, s_ra;
    logic [10:0]   s_wn;
    logic [EW:0]   s_wp;

    always_ff @(posedge i_clk) begin
        if (e_we) begin
            m_efrom[e_wa] <= r_item.first_node;
            m_eto[e_wa] <= r_item.second_node;
        end
        r_efrom_q <= m_efrom[e_ra];
        r_eto_q <= m_eto[e_ra];
        if (v_we) m_vis[v_wa] <= v_wd;
        r_vis_q <= m_vis[v_ra];
        if (l_we) m_lbl[l_wa] <= l_wd;
        r_lbl_q <= m_lbl[l_ra];
        if (f_we) m_fin[f_wa] <= f_wd;
        r_fin_q <= m_fin[f_ra];
        if (s_we) begin
            m_snode[s_wa] <= s_wn;
            m_spos[s_wa] <= s_wp;
        end
        r_snode_q <= m_snode[s_ra];
        r_spos_q <= m_spos[s_ra];
    end

    logic [NW-1:0] w_top;
    logic          w_edge_more;
    logic [10:0]   w_ea, w_eb;
    assign w_top = NW'(r_sp - 1'b1);
    assign w_edge_more = (r_p < r_edge_total);

    always_comb begin
        e_we = 1'b0; e_wa = r_edge_total[EW-1:0]; e_ra = r_p[EW-1:0];
        v_we = 1'b0; v_wd = 1'b0; v_wa = r_cnt[NW-1:0]; v_ra = nidx(r_b);
        l_we = 1'b0; l_wd = '0; l_wa = r_cnt[NW-1:0]; l_ra = nidx(r_b);
        f_we = 1'b0; f_wa = r_fin[NW-1:0]; f_ra = NW'(r_fin - 1'b1); f_wd = r_u;
        s_we = 1'b0; s_wa = w_top; s_ra = w_top; s_wn = r_b; s_wp = '0;
        w_ea = r_efrom_q; w_eb = r_eto_q;
        if (r_state inside {S_B_ECHK}) begin
            w_ea = r_eto_q; w_eb = r_efrom_q;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_in.kind == scc_pkg::KindQuery) begin
                    l_ra = nidx(i_in.first_node);
                end
            end
            S_QRD: l_ra = nidx(r_item.second_node);
            S_CLR: begin
                v_we = 1'b1; l_we = 1'b1;
            end
            S_F_SEL: v_ra = r_cnt[NW-1:0];
            S_F_RD: begin
                v_we = 1'b1; v_wd = 1'b1; v_wa = r_cnt[NW-1:0];
                s_we = 1'b1; s_wa = '0; s_wn = 11'(r_cnt) + 11'd1;
            end
            S_F_ECHK, S_B_ECHK: begin
                v_ra = nidx(w_eb); l_ra = nidx(w_eb);
            end
            S_F_VCHK: begin
                if (!r_vis_q && r_sp < (NW+1)'(scc_pkg::MaxNodes)) begin
                    v_we = 1'b1; v_wd = 1'b1; v_wa = nidx(r_b);
                    s_we = 1'b1; s_wa = w_top; s_wn = r_u; s_wp = r_p;
                end
            end
            S_F_EWAIT: begin
                if (!w_edge_more && r_fin < (NW+1)'(scc_pkg::MaxNodes)) f_we = 1'b1;
            end
            S_B_LWAIT: l_ra = nidx(r_fin_q);
            S_B_LCHK: begin
                if (node_ok(r_u, r_n) && r_lbl_q == 11'd0) begin
                    l_we = 1'b1; l_wa = nidx(r_u); l_wd = r_count + 11'd1;
                    s_we = 1'b1; s_wa = '0; s_wn = r_u;
                end
            end
            S_B_LCHK2: begin
                if (r_lbl_q == 11'd0 && r_sp < (NW+1)'(scc_pkg::MaxNodes)) begin
                    l_we = 1'b1; l_wa = nidx(r_b); l_wd = r_count;
                    s_we = 1'b1; s_wa = w_top; s_wn = r_u; s_wp = r_p;
                end
            end
            default: ;
        endcase
        if (r_state == S_QRD && r_item.kind == scc_pkg::KindAdd && w_add_ok
            && r_edge_total < (EW+1)'(scc_pkg::MaxEdges)) e_we = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_node_count <= 11'd1024;
            r_edge_total <= '0;
            r_ready_lbl <= 1'b0;
            r_sp <= '0;
            r_fin <= '0;
        end else begin
            if (i_cfg_we) r_node_count <= i_cfg_data;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item <= i_in;
                        r_out <= '0;
                        r_n <= w_n_eff;
                        r_cnt <= '0;
                        r_state <= S_QRD;
                    end
                end
                S_QRD: begin
                    r_a <= r_lbl_q;
                    r_state <= S_OUT;
                    case (r_item.kind)
                        scc_pkg::KindAdd: begin
                            if (!w_add_ok) begin
                                r_out.status <= scc_pkg::StatRange;
                            end else if (r_edge_total >= (EW+1)'(scc_pkg::MaxEdges)) begin
                                r_out.status <= scc_pkg::StatFull;
                            end else begin
                                r_edge_total <= r_edge_total + 1'b1;
                                r_ready_lbl <= 1'b0;
                            end
                        end
                        scc_pkg::KindRun: begin
                            r_fin <= '0;
                            r_count <= '0;
                            r_state <= S_CLR;
                        end
                        scc_pkg::KindQuery: r_state <= S_QCMP;
                        default: begin
                            r_edge_total <= '0;
                            r_ready_lbl <= 1'b0;
                        end
                    endcase
                end
                S_QCMP: begin
                    if (!r_ready_lbl) r_out.status <= scc_pkg::StatNotRun;
                    else if (!w_add_ok) r_out.status <= scc_pkg::StatRange;
                    else r_out.same_component <= (r_a == r_lbl_q);
                    r_state <= S_OUT;
                end
                S_CLR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == (NW+1)'(scc_pkg::MaxNodes - 1)) begin
                        r_cnt <= '0;
                        r_state <= S_F_SEL;
                    end
                end
                S_F_SEL: begin
                    if (r_cnt >= (NW+1)'(r_n)) begin
                        r_state <= S_B_POP;
                        r_count <= '0;
                    end else begin
                        r_state <= S_F_RD;
                    end
                end
                S_F_RD: begin
                    if (r_vis_q) begin
                        r_cnt <= r_cnt + 1'b1;
                        r_state <= S_F_SEL;
                    end else begin
                        r_sp <= (NW+1)'(1);
                        r_state <= S_F_TOP;
                    end
                end
                S_F_TOP, S_B_TOP: r_state <= (r_state == S_F_TOP) ? S_F_ERD : S_B_ERD;
                S_F_ERD, S_B_ERD: begin
                    r_u <= r_snode_q;
                    r_p <= r_spos_q;
                    r_state <= (r_state == S_F_ERD) ? S_F_EWAIT : S_B_EWAIT;
                end
                S_F_EWAIT, S_B_EWAIT: begin
                    if (!w_edge_more) begin
                        if (r_state == S_F_EWAIT) begin
                            if (r_fin < (NW+1)'(scc_pkg::MaxNodes)) r_fin <= r_fin + 1'b1;
                        end
                        r_sp <= r_sp - 1'b1;
                        if (r_sp == (NW+1)'(1)) begin
                            r_state <= (r_state == S_F_EWAIT) ? S_F_SEL : S_B_POP;
                            if (r_state == S_F_EWAIT) r_cnt <= r_cnt + 1'b1;
                        end else begin
                            r_state <= (r_state == S_F_EWAIT) ? S_F_TOP : S_B_TOP;
                        end
                    end else begin
                        r_p <= r_p + 1'b1;
                        r_state <= (r_state == S_F_EWAIT) ? S_F_ECHK : S_B_ECHK;
                    end
                end
                S_F_ECHK, S_B_ECHK: begin
                    r_b <= w_eb;
                    if (w_ea == r_u && node_ok(w_ea, r_n) && node_ok(w_eb, r_n)) begin
                        r_state <= (r_state == S_F_ECHK) ? S_F_VWAIT : S_B_LWAIT2;
                    end else begin
                        r_state <= (r_state == S_F_ECHK) ? S_F_EWAIT : S_B_EWAIT;
                    end
                end
                S_F_VWAIT: r_state <= S_F_VCHK;
                S_B_LWAIT2: r_state <= S_B_LCHK2;
                S_F_VCHK, S_B_LCHK2: begin
                    if ((r_state == S_F_VCHK ? !r_vis_q : r_lbl_q == 11'd0)
                        && r_sp < (NW+1)'(scc_pkg::MaxNodes)) begin
                        r_sp <= r_sp + 1'b1;
                        r_u <= r_b;
                        r_p <= '0;
                        r_state <= (r_state == S_F_VCHK) ? S_F_EWAIT : S_B_EWAIT;
                    end else begin
                        r_state <= (r_state == S_F_VCHK) ? S_F_EWAIT : S_B_EWAIT;
                    end
                end
                S_B_POP: begin
                    if (r_fin == '0) begin
                        r_ready_lbl <= 1'b1;
                        r_out.component_total <= r_count;
                        r_state <= S_OUT;
                    end else begin
                        r_fin <= r_fin - 1'b1;
                        r_state <= S_B_LWAIT;
                    end
                end
                S_B_LWAIT: begin
                    r_u <= r_fin_q;
                    r_state <= S_B_LCHK;
                end
                S_B_LCHK: begin
                    if (node_ok(r_u, r_n) && r_lbl_q == 11'd0) begin
                        r_count <= r_count + 11'd1;
                        r_p <= '0;
                        r_sp <= (NW+1)'(1);
                        r_state <= S_B_EWAIT;
                    end else begin
                        r_state <= S_B_POP;
                    end
                end
                S_OUT: if (i_out_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out = r_out;

    `SCC_ASSERT_IMP(a_one_side, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    `SCC_ASSERT_IMP(a_sp_bound, i_clk, i_rst_n, 1'b1, r_sp <= (NW+1)'(scc_pkg::MaxNodes))
    `SCC_ASSERT_IMP(a_edges_bound, i_clk, i_rst_n, 1'b1,
                    r_edge_total <= (EW+1)'(scc_pkg::MaxEdges))
endmodule
`default_nettype wire
